>>> rtl/dual_hbridge_slew_reverse_ctrl_assert.svh
// Assertion macros for the dual H-bridge drive controller.
// Used by the top level; relies on signals named clk and rst in the including scope.
`ifndef DUAL_HBRIDGE_SLEW_REVERSE_CTRL_ASSERT_SVH
`define DUAL_HBRIDGE_SLEW_REVERSE_CTRL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HBSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbsr assertion failed");

// Next-cycle implication, disabled during reset.
`define HBSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbsr assertion failed");

`endif

>>> rtl/hbsr_pkg.sv
// Shared types, codes, constants and helper functions of the dual H-bridge controller.
// No dependencies; used by the channel, scale and top-level modules and by the testbench.
`timescale 1ns / 1ps

package hbsr_pkg;

  localparam int unsigned SPEED_W = 10;

  localparam logic [SPEED_W-1:0] SPEED_LIMIT     = 10'd1000;
  localparam logic [15:0]        AR_RESET        = 16'd3199;
  localparam logic [SPEED_W-1:0] STEP_RESET      = 10'd50;
  localparam logic [15:0]        WAIT_RESET      = 16'd100;
  // floor(2^32 / 1000), used to divide the PWM product by the speed limit.
  localparam logic [22:0]        RECIP_LIMIT     = 23'd4294967;
  localparam logic [25:0]        LIMIT_WIDE      = 26'd1000;

  typedef enum logic [1:0] {
    DIR_FWD   = 2'd0,
    DIR_REV   = 2'd1,
    DIR_BRAKE = 2'd2,
    DIR_COAST = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    CMD_UPDATE      = 3'd0,
    CMD_SET_DIR_SPD = 3'd1,
    CMD_SET_DIR     = 3'd2,
    CMD_SET_SPD     = 3'd3,
    CMD_STOP        = 3'd4,
    CMD_EMERGENCY   = 3'd5,
    CMD_STANDBY_ON  = 3'd6,
    CMD_STANDBY_OFF = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    REG_AUTO_RELOAD  = 2'd0,
    REG_SLEW_STEP    = 2'd1,
    REG_REVERSE_WAIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               update;
    logic               emergency;
    logic               set_dir;
    logic               set_speed;
    dir_t               dir;
    logic [SPEED_W-1:0] speed;
    logic [31:0]        now_ms;
    logic [SPEED_W-1:0] slew_step;
    logic [15:0]        reverse_wait_ms;
  } chan_cmd_t;

  typedef struct packed {
    dir_t               dir;
    logic [SPEED_W-1:0] speed;
    logic               reversing;
  } chan_state_t;

  function automatic logic is_turning(dir_t d);
    return (d == DIR_FWD) || (d == DIR_REV);
  endfunction

  // Returns {in2, in1} for a direction.
  function automatic logic [1:0] dir_pins(dir_t d);
    logic in1;
    logic in2;
    in1 = (d == DIR_FWD) || (d == DIR_BRAKE);
    in2 = (d == DIR_REV) || (d == DIR_BRAKE);
    return {in2, in1};
  endfunction

endpackage

>>> rtl/hbsr_channel.sv
// State and next-state logic of one motor channel: goal, slew and reversal sequence.
// Depends on hbsr_pkg.
`timescale 1ns / 1ps

module hbsr_channel (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  hbsr_pkg::chan_cmd_t cmd,
  output hbsr_pkg::chan_state_t state_next
);

  hbsr_pkg::dir_t                goal_dir;
  hbsr_pkg::dir_t                goal_dir_next;
  hbsr_pkg::dir_t                applied_dir;
  hbsr_pkg::dir_t                applied_dir_next;
  logic [hbsr_pkg::SPEED_W-1:0]  goal_speed;
  logic [hbsr_pkg::SPEED_W-1:0]  goal_speed_next;
  logic [hbsr_pkg::SPEED_W-1:0]  applied_speed;
  logic [hbsr_pkg::SPEED_W-1:0]  applied_speed_next;
  logic [31:0]                   rev_start;
  logic [31:0]                   rev_start_next;
  logic                          in_reversal;
  logic                          in_reversal_next;

  logic [hbsr_pkg::SPEED_W-1:0]  step_down;
  logic [hbsr_pkg::SPEED_W:0]    step_up;
  logic [31:0]                   elapsed;
  logic                          hold;

  assign step_down = (applied_speed > cmd.slew_step) ? (applied_speed - cmd.slew_step)
                                                     : '0;
  assign step_up   = {1'b0, applied_speed} + {1'b0, cmd.slew_step};
  assign elapsed   = cmd.now_ms - rev_start;

  always_comb begin
    goal_dir_next      = goal_dir;
    goal_speed_next    = goal_speed;
    applied_dir_next   = applied_dir;
    applied_speed_next = applied_speed;
    rev_start_next     = rev_start;
    in_reversal_next   = in_reversal;
    hold               = 1'b0;
    if (cmd.emergency) begin
      goal_dir_next      = hbsr_pkg::DIR_BRAKE;
      goal_speed_next    = '0;
      applied_dir_next   = hbsr_pkg::DIR_BRAKE;
      applied_speed_next = '0;
      in_reversal_next   = 1'b0;
    end else if (cmd.update) begin
      if (in_reversal) begin
        if (applied_speed != '0) begin
          applied_speed_next = step_down;
          hold               = 1'b1;
        end else if (elapsed < {16'b0, cmd.reverse_wait_ms}) begin
          hold = 1'b1;
        end else begin
          in_reversal_next = 1'b0;
        end
      end
      if (!hold) begin
        if (!in_reversal && hbsr_pkg::is_turning(applied_dir) &&
            hbsr_pkg::is_turning(goal_dir) && (applied_dir != goal_dir) &&
            (applied_speed != '0)) begin
          in_reversal_next = 1'b1;
          rev_start_next   = cmd.now_ms;
        end else begin
          applied_dir_next = goal_dir;
          if (applied_speed < goal_speed) begin
            applied_speed_next = (step_up > {1'b0, goal_speed}) ? goal_speed
                                                                : step_up[hbsr_pkg::SPEED_W-1:0];
          end else if (applied_speed > goal_speed) begin
            applied_speed_next = (step_down < goal_speed) ? goal_speed : step_down;
          end
        end
      end
    end else begin
      if (cmd.set_dir) begin
        goal_dir_next = cmd.dir;
      end
      if (cmd.set_speed) begin
        goal_speed_next = cmd.speed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_dir      <= hbsr_pkg::DIR_COAST;
      goal_speed    <= '0;
      applied_dir   <= hbsr_pkg::DIR_COAST;
      applied_speed <= '0;
      rev_start     <= '0;
      in_reversal   <= 1'b0;
    end else if (accept) begin
      goal_dir      <= goal_dir_next;
      goal_speed    <= goal_speed_next;
      applied_dir   <= applied_dir_next;
      applied_speed <= applied_speed_next;
      rev_start     <= rev_start_next;
      in_reversal   <= in_reversal_next;
    end
  end

  // With no item accepted the next state equals the current one.
  always_comb begin
    if (accept) begin
      state_next.dir       = applied_dir_next;
      state_next.speed     = applied_speed_next;
      state_next.reversing = in_reversal_next;
    end else begin
      state_next.dir       = applied_dir;
      state_next.speed     = applied_speed;
      state_next.reversing = in_reversal;
    end
  end

endmodule

>>> rtl/hbsr_scale.sv
// Two-stage PWM compare scaling: speed * auto_reload, then division by the speed limit.
// The division uses a reciprocal product with one correction step. Depends on hbsr_pkg.
`timescale 1ns / 1ps

module hbsr_scale (
  input  logic                               clk,
  input  logic                               load_prod,
  input  logic                               load_quot,
  input  logic [hbsr_pkg::SPEED_W-1:0]       speed,
  input  logic [15:0]                        auto_reload,
  output logic [15:0]                        compare_next
);

  logic [25:0] prod;
  logic [25:0] prod_q;
  logic [15:0] quot;
  logic [47:0] recip_prod;
  logic [25:0] back;
  logic [25:0] rem;
  logic [15:0] quot_fix;

  assign recip_prod = 48'(prod) * 48'(hbsr_pkg::RECIP_LIMIT);

  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod <= {16'b0, speed} * {10'b0, auto_reload};
    end
    if (load_quot) begin
      prod_q <= prod;
      quot   <= recip_prod[47:32];
    end
  end

  // The reciprocal estimate is the exact quotient or one below it.
  assign back         = {10'b0, quot} * hbsr_pkg::LIMIT_WIDE;
  assign rem          = prod_q - back;
  assign quot_fix     = (rem >= hbsr_pkg::LIMIT_WIDE) ? (quot + 16'd1) : quot;
  assign compare_next = (quot_fix > auto_reload) ? auto_reload : quot_fix;

endmodule

>>> rtl/dual_hbridge_slew_reverse_ctrl.sv
// Top level of the dual H-bridge drive controller: command decode, configuration,
// channel state, output pipeline. Depends on hbsr_pkg, hbsr_channel, hbsr_scale.
//
//   Channel   Handshake                Payload
//   s_*       s_tvalid / s_tready      s_tuser: cmd, channel; s_tdata: direction, speed, now_ms
//   m_*       m_tvalid / m_tready      m_tdata: pins, compare values, standby, reversal flags
//   cfg_*     cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item is accepted per cycle while s_tready is high; each result is registered stage by stage.
// The pipeline stages are: state update, speed product, reciprocal product, correction.
// Each stage has its own valid bit, so bubbles are squeezed out while m_tready is low.
// Synchronous reset restores the channel state and the register defaults; cfg_ready stays high.
`timescale 1ns / 1ps

module dual_hbridge_slew_reverse_ctrl (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [3:0]  s_tuser,   // cmd[2:0], channel[3]
  input  logic [55:0] s_tdata,   // direction[1:0], speed[17:2], now_ms[49:18], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  // a_in1[0], a_in2[1], b_in1[2], b_in2[3], compare_a[19:4], compare_b[35:20],
  // standby_n[36], reversing_a[37], reversing_b[38], zero fill[39]
  output logic [39:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef struct packed {
    hbsr_pkg::dir_t dir_a;
    hbsr_pkg::dir_t dir_b;
    logic           standby_n;
    logic           rev_a;
    logic           rev_b;
  } flags_t;

  logic [15:0]                  auto_reload;
  logic [hbsr_pkg::SPEED_W-1:0] slew_step;
  logic [15:0]                  reverse_wait_ms;
  logic                         driver_enabled;
  logic                         driver_enabled_next;

  hbsr_pkg::cmd_t               cmd;
  logic                         chan_sel;
  hbsr_pkg::dir_t               dir_in;
  logic [15:0]                  speed_raw;
  logic [hbsr_pkg::SPEED_W-1:0] speed_clamped;
  logic                         set_dir;
  logic                         set_speed;
  logic                         accept;
  hbsr_pkg::chan_cmd_t          cmd_a;
  hbsr_pkg::chan_cmd_t          cmd_b;
  hbsr_pkg::chan_state_t        state_a_next;
  hbsr_pkg::chan_state_t        state_b_next;

  logic                         v1;
  logic                         v2;
  logic                         v3;
  logic                         ready1;
  logic                         ready2;
  logic                         ready3;
  logic                         adv_out;
  flags_t                       flags1;
  flags_t                       flags2;
  flags_t                       flags3;
  flags_t                       flags_out;
  logic [hbsr_pkg::SPEED_W-1:0] speed1_a;
  logic [hbsr_pkg::SPEED_W-1:0] speed1_b;
  logic [15:0]                  cmp_a_next;
  logic [15:0]                  cmp_b_next;
  logic [15:0]                  cmp_a;
  logic [15:0]                  cmp_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_reload     <= hbsr_pkg::AR_RESET;
      slew_step       <= hbsr_pkg::STEP_RESET;
      reverse_wait_ms <= hbsr_pkg::WAIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hbsr_pkg::REG_AUTO_RELOAD:  auto_reload     <= cfg_data;
        hbsr_pkg::REG_SLEW_STEP:    slew_step       <= cfg_data[hbsr_pkg::SPEED_W-1:0];
        hbsr_pkg::REG_REVERSE_WAIT: reverse_wait_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cmd           = hbsr_pkg::cmd_t'(s_tuser[2:0]);
  assign chan_sel      = s_tuser[3];
  assign speed_raw     = s_tdata[17:2];
  assign speed_clamped = (speed_raw > {6'b0, hbsr_pkg::SPEED_LIMIT}) ? hbsr_pkg::SPEED_LIMIT
                                                                     : speed_raw[9:0];
  assign accept        = s_tvalid && s_tready;

  always_comb begin
    set_dir             = 1'b0;
    set_speed           = 1'b0;
    dir_in              = hbsr_pkg::dir_t'(s_tdata[1:0]);
    driver_enabled_next = driver_enabled;
    case (cmd)
      hbsr_pkg::CMD_SET_DIR_SPD: begin
        set_dir   = 1'b1;
        set_speed = 1'b1;
      end
      hbsr_pkg::CMD_SET_DIR: set_dir = 1'b1;
      hbsr_pkg::CMD_SET_SPD: set_speed = 1'b1;
      hbsr_pkg::CMD_STOP: begin
        set_dir   = 1'b1;
        set_speed = 1'b1;
        dir_in    = hbsr_pkg::DIR_COAST;
      end
      hbsr_pkg::CMD_EMERGENCY:   driver_enabled_next = 1'b0;
      hbsr_pkg::CMD_STANDBY_ON:  driver_enabled_next = 1'b0;
      hbsr_pkg::CMD_STANDBY_OFF: driver_enabled_next = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    cmd_a.update          = (cmd == hbsr_pkg::CMD_UPDATE);
    cmd_a.emergency       = (cmd == hbsr_pkg::CMD_EMERGENCY);
    cmd_a.set_dir         = set_dir && !chan_sel;
    cmd_a.set_speed       = set_speed && !chan_sel;
    cmd_a.dir             = dir_in;
    cmd_a.speed           = (cmd == hbsr_pkg::CMD_STOP) ? '0 : speed_clamped;
    cmd_a.now_ms          = s_tdata[49:18];
    cmd_a.slew_step       = slew_step;
    cmd_a.reverse_wait_ms = reverse_wait_ms;
    cmd_b                 = cmd_a;
    cmd_b.set_dir         = set_dir && chan_sel;
    cmd_b.set_speed       = set_speed && chan_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      driver_enabled <= 1'b1;
    end else if (accept) begin
      driver_enabled <= driver_enabled_next;
    end
  end

  hbsr_channel u_chan_a (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd_a),
    .state_next (state_a_next)
  );

  hbsr_channel u_chan_b (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd_b),
    .state_next (state_b_next)
  );

  assign adv_out  = !m_tvalid || m_tready;
  assign ready3   = !v3 || adv_out;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= s_tvalid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (adv_out) begin
        m_tvalid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      flags1.dir_a     <= state_a_next.dir;
      flags1.dir_b     <= state_b_next.dir;
      flags1.standby_n <= accept ? driver_enabled_next : driver_enabled;
      flags1.rev_a     <= state_a_next.reversing;
      flags1.rev_b     <= state_b_next.reversing;
      speed1_a         <= state_a_next.speed;
      speed1_b         <= state_b_next.speed;
    end
    if (ready2) begin
      flags2 <= flags1;
    end
    if (ready3) begin
      flags3 <= flags2;
    end
    if (adv_out) begin
      flags_out <= flags3;
      cmp_a     <= cmp_a_next;
      cmp_b     <= cmp_b_next;
    end
  end

  hbsr_scale u_scale_a (
    .clk          (clk),
    .load_prod    (ready2),
    .load_quot    (ready3),
    .speed        (speed1_a),
    .auto_reload  (auto_reload),
    .compare_next (cmp_a_next)
  );

  hbsr_scale u_scale_b (
    .clk          (clk),
    .load_prod    (ready2),
    .load_quot    (ready3),
    .speed        (speed1_b),
    .auto_reload  (auto_reload),
    .compare_next (cmp_b_next)
  );

  assign m_tdata = {1'b0, flags_out.rev_b, flags_out.rev_a, flags_out.standby_n,
                    cmp_b, cmp_a,
                    hbsr_pkg::dir_pins(flags_out.dir_b), hbsr_pkg::dir_pins(flags_out.dir_a)};

`include "dual_hbridge_slew_reverse_ctrl_assert.svh"

  `HBSR_ASSERT_NOW(a_stall_full, !s_tready, v1 && v2 && v3 && m_tvalid)
  `HBSR_ASSERT_NOW(a_rev_turning_a, state_a_next.reversing,
                   (state_a_next.dir == hbsr_pkg::DIR_FWD) ||
                   (state_a_next.dir == hbsr_pkg::DIR_REV))
  `HBSR_ASSERT_NOW(a_rev_turning_b, state_b_next.reversing,
                   (state_b_next.dir == hbsr_pkg::DIR_FWD) ||
                   (state_b_next.dir == hbsr_pkg::DIR_REV))
  `HBSR_ASSERT_NEXT(a_emergency_stop, accept && (cmd == hbsr_pkg::CMD_EMERGENCY),
                    (speed1_a == '0) && (speed1_b == '0) && !flags1.standby_n)

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the dual H-bridge drive controller.
// Depends on hbsr_pkg and dual_hbridge_slew_reverse_ctrl; predicts every result
// from its own model of the channel state and checks it field by field.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic        rev_b;
    logic        rev_a;
    logic        standby_n;
    logic [15:0] cmp_b;
    logic [15:0] cmp_a;
    logic        b_in2;
    logic        b_in1;
    logic        a_in2;
    logic        a_in1;
  } drive_out_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [3:0]  s_tuser = '0;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dual_hbridge_slew_reverse_ctrl uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Model of the controller state and registers.
  hbsr_pkg::dir_t goal_dir [2];
  hbsr_pkg::dir_t run_dir [2];
  bit [9:0]    goal_spd [2];
  bit [9:0]    run_spd [2];
  bit [31:0]   rev_t0 [2];
  bit          rev_on [2];
  bit          drv_en;
  bit [15:0]   pwm_period;
  bit [9:0]    slew_limit;
  bit [15:0]   reverse_hold;

  drive_out_t  pending_outputs [$];
  int          send_idle = 37;
  int          rcv_idle = 59;
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          reg_writes = 0;
  int          rev_started = 0;
  int          rev_finished = 0;
  int          quiet_cycles = 0;
  bit [31:0]   clock_ms;

  initial begin
    for (int c = 0; c < 2; c++) begin
      goal_dir[c] = hbsr_pkg::DIR_COAST;
      run_dir[c] = hbsr_pkg::DIR_COAST;
      goal_spd[c] = '0;
      run_spd[c] = '0;
      rev_t0[c] = '0;
      rev_on[c] = 1'b0;
    end
    drv_en = 1'b1;
    pwm_period = hbsr_pkg::AR_RESET;
    slew_limit = hbsr_pkg::STEP_RESET;
    reverse_hold = hbsr_pkg::WAIT_RESET;
  end

  function automatic bit spinning(hbsr_pkg::dir_t d);
    return d == hbsr_pkg::DIR_FWD || d == hbsr_pkg::DIR_REV;
  endfunction

  function automatic bit [9:0] ramp_down(bit [9:0] v);
    return (v > slew_limit) ? v - slew_limit : 10'd0;
  endfunction

  function automatic void step_channel(int c, bit [31:0] now);
    bit [31:0]   gone;
    int unsigned s;
    if (rev_on[c]) begin
      if (run_spd[c] > 0) begin
        run_spd[c] = ramp_down(run_spd[c]);
        return;
      end
      gone = now - rev_t0[c];
      if (gone < reverse_hold) return;
      rev_on[c] = 1'b0;
      run_dir[c] = goal_dir[c];
      rev_finished++;
    end
    if (spinning(run_dir[c]) && spinning(goal_dir[c]) && run_dir[c] != goal_dir[c] &&
        run_spd[c] > 0) begin
      rev_on[c] = 1'b1;
      rev_t0[c] = now;
      rev_started++;
      return;
    end
    run_dir[c] = goal_dir[c];
    if (run_spd[c] < goal_spd[c]) begin
      s = 32'(run_spd[c]) + 32'(slew_limit);
      run_spd[c] = (s > goal_spd[c]) ? goal_spd[c] : s[9:0];
    end else if (run_spd[c] > goal_spd[c]) begin
      s = 32'(ramp_down(run_spd[c]));
      run_spd[c] = (s < goal_spd[c]) ? goal_spd[c] : s[9:0];
    end
  endfunction

  function automatic bit [15:0] duty_count(bit [9:0] s);
    int unsigned v;
    v = 32'(s);
    v = v * pwm_period / 1000;
    if (v > pwm_period) v = 32'(pwm_period);
    return v[15:0];
  endfunction

  function automatic bit [1:0] pin_pair(hbsr_pkg::dir_t d);
    case (d)
      hbsr_pkg::DIR_FWD:   return 2'b01;
      hbsr_pkg::DIR_REV:   return 2'b10;
      hbsr_pkg::DIR_BRAKE: return 2'b11;
      default:             return 2'b00;
    endcase
  endfunction

  function automatic drive_out_t apply_item(hbsr_pkg::cmd_t cmd, bit chan,
                                            hbsr_pkg::dir_t dir, bit [15:0] spd_in,
                                            bit [31:0] now);
    bit [9:0]   spd;
    drive_out_t r;
    spd = (spd_in > hbsr_pkg::SPEED_LIMIT) ? hbsr_pkg::SPEED_LIMIT : spd_in[9:0];
    case (cmd)
      hbsr_pkg::CMD_UPDATE: begin
        step_channel(0, now);
        step_channel(1, now);
      end
      hbsr_pkg::CMD_SET_DIR_SPD: begin
        goal_dir[chan] = dir;
        goal_spd[chan] = spd;
      end
      hbsr_pkg::CMD_SET_DIR: goal_dir[chan] = dir;
      hbsr_pkg::CMD_SET_SPD: goal_spd[chan] = spd;
      hbsr_pkg::CMD_STOP: begin
        goal_dir[chan] = hbsr_pkg::DIR_COAST;
        goal_spd[chan] = '0;
      end
      hbsr_pkg::CMD_EMERGENCY: begin
        for (int c = 0; c < 2; c++) begin
          goal_dir[c] = hbsr_pkg::DIR_BRAKE;
          run_dir[c] = hbsr_pkg::DIR_BRAKE;
          goal_spd[c] = '0;
          run_spd[c] = '0;
          rev_on[c] = 1'b0;
        end
        drv_en = 1'b0;
      end
      hbsr_pkg::CMD_STANDBY_ON: drv_en = 1'b0;
      default: drv_en = 1'b1;
    endcase
    {r.a_in2, r.a_in1} = pin_pair(run_dir[0]);
    {r.b_in2, r.b_in1} = pin_pair(run_dir[1]);
    r.cmp_a = duty_count(run_spd[0]);
    r.cmp_b = duty_count(run_spd[1]);
    r.standby_n = drv_en;
    r.rev_a = rev_on[0];
    r.rev_b = rev_on[1];
    return r;
  endfunction

  task automatic send_item(hbsr_pkg::cmd_t cmd, bit chan, hbsr_pkg::dir_t dir, bit [15:0] spd,
                           bit [31:0] now);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {chan, cmd};
    s_tdata <= {6'd0, now, spd, dir};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_outputs.push_back(apply_item(cmd, chan, dir, spd, now));
    items_sent++;
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(hbsr_pkg::cfg_reg_t idx, bit [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      hbsr_pkg::REG_AUTO_RELOAD: pwm_period = value;
      hbsr_pkg::REG_SLEW_STEP:   slew_limit = value[9:0];
      default:                   reverse_hold = value;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_regs(bit [15:0] period, bit [15:0] slew, bit [15:0] hold);
    wait_all_results();
    write_reg(hbsr_pkg::REG_AUTO_RELOAD, period);
    write_reg(hbsr_pkg::REG_SLEW_STEP, slew);
    write_reg(hbsr_pkg::REG_REVERSE_WAIT, hold);
  endtask

  task automatic send_random_item();
    int             r;
    hbsr_pkg::cmd_t cmd;
    hbsr_pkg::dir_t dir;
    bit [15:0]      spd;
    bit [31:0]      now;
    r = $urandom_range(99);
    if (r < 45)      cmd = hbsr_pkg::CMD_UPDATE;
    else if (r < 65) cmd = hbsr_pkg::CMD_SET_DIR_SPD;
    else if (r < 75) cmd = hbsr_pkg::CMD_SET_DIR;
    else if (r < 83) cmd = hbsr_pkg::CMD_SET_SPD;
    else if (r < 88) cmd = hbsr_pkg::CMD_STOP;
    else if (r < 92) cmd = hbsr_pkg::CMD_STANDBY_ON;
    else if (r < 97) cmd = hbsr_pkg::CMD_STANDBY_OFF;
    else             cmd = hbsr_pkg::CMD_EMERGENCY;
    r = $urandom_range(99);
    if (r < 40)      dir = hbsr_pkg::DIR_FWD;
    else if (r < 80) dir = hbsr_pkg::DIR_REV;
    else if (r < 90) dir = hbsr_pkg::DIR_BRAKE;
    else             dir = hbsr_pkg::DIR_COAST;
    spd = ($urandom_range(99) < 80) ? 16'($urandom_range(1000)) : 16'($urandom_range(65535));
    if (cmd == hbsr_pkg::CMD_UPDATE) begin
      if ($urandom_range(99) < 3) clock_ms = clock_ms + $urandom;
      else clock_ms = clock_ms + $urandom_range(25);
      now = clock_ms;
    end else begin
      now = $urandom;
    end
    send_item(cmd, 1'($urandom_range(1)), dir, spd, now);
  endtask

  task automatic test_reset_state();
    send_item(hbsr_pkg::CMD_UPDATE, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'd0);
    send_item(hbsr_pkg::CMD_STANDBY_OFF, 1'b1, hbsr_pkg::DIR_COAST, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed_commands();
    set_regs(hbsr_pkg::AR_RESET, 16'd400, 16'd20);
    send_item(hbsr_pkg::CMD_SET_DIR_SPD, 1'b0, hbsr_pkg::DIR_FWD, 16'hFFFF, 32'd0);
    send_item(hbsr_pkg::CMD_SET_DIR_SPD, 1'b1, hbsr_pkg::DIR_REV, 16'd1000, 32'd0);
    send_item(hbsr_pkg::CMD_UPDATE, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'hFFFF_FFF0);
    send_item(hbsr_pkg::CMD_UPDATE, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'hFFFF_FFF5);
    send_item(hbsr_pkg::CMD_UPDATE, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'hFFFF_FFFA);
    // Reversal on A that spans the wrap of the millisecond clock.
    send_item(hbsr_pkg::CMD_SET_DIR, 1'b0, hbsr_pkg::DIR_REV, 16'd0, 32'd0);
    send_item(hbsr_pkg::CMD_UPDATE, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'hFFFF_FFFC);
    send_item(hbsr_pkg::CMD_UPDATE, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'hFFFF_FFFE);
    send_item(hbsr_pkg::CMD_UPDATE, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'hFFFF_FFFF);
    // The goal moves while the sequence is running.
    send_item(hbsr_pkg::CMD_SET_DIR, 1'b0, hbsr_pkg::DIR_BRAKE, 16'd0, 32'd0);
    send_item(hbsr_pkg::CMD_SET_DIR_SPD, 1'b0, hbsr_pkg::DIR_REV, 16'd700, 32'd0);
    send_item(hbsr_pkg::CMD_UPDATE, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'd1);
    send_item(hbsr_pkg::CMD_UPDATE, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'd5);
    send_item(hbsr_pkg::CMD_UPDATE, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'h10);
    send_item(hbsr_pkg::CMD_SET_SPD, 1'b1, hbsr_pkg::DIR_FWD, 16'd0, 32'd0);
    send_item(hbsr_pkg::CMD_STOP, 1'b1, hbsr_pkg::DIR_FWD, 16'd0, 32'd0);
    send_item(hbsr_pkg::CMD_UPDATE, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'h20);
    send_item(hbsr_pkg::CMD_STANDBY_ON, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'd0);
    send_item(hbsr_pkg::CMD_UPDATE, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'h30);
    send_item(hbsr_pkg::CMD_STANDBY_OFF, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'd0);
    send_item(hbsr_pkg::CMD_EMERGENCY, 1'b1, hbsr_pkg::DIR_FWD, 16'd0, 32'd0);
    send_item(hbsr_pkg::CMD_UPDATE, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'h40);
    send_item(hbsr_pkg::CMD_STANDBY_OFF, 1'b0, hbsr_pkg::DIR_FWD, 16'd0, 32'd0);
  endtask

  task automatic test_register_extremes();
    set_regs(16'hFFFF, 16'd1023, 16'd0);
    clock_ms = $urandom;
    repeat (12) send_random_item();
    // A zero slew step freezes the speeds, and a reversal never completes.
    set_regs(16'd0, 16'd0, 16'hFFFF);
    repeat (12) send_random_item();
    set_regs(16'd1, 16'd1, 16'd1);
    repeat (12) send_random_item();
  endtask

  task automatic test_random_traffic(int n, int s_idle, int r_idle, bit [15:0] period,
                                     bit [15:0] slew, bit [15:0] hold);
    set_regs(period, slew, hold);
    send_idle = s_idle;
    rcv_idle = r_idle;
    clock_ms = 32'hFFFF_FFFF - $urandom_range(4000);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_all_results();
      send_random_item();
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rcv_idle);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: result %0d arrived with nothing expected",
                                       results_checked);
      end else begin
        drive_out_t want;
        drive_out_t got;
        want = pending_outputs.pop_front();
        got = m_tdata[38:0];
        if (got.a_in1 !== want.a_in1 || got.a_in2 !== want.a_in2 ||
            got.b_in1 !== want.b_in1 || got.b_in2 !== want.b_in2 ||
            got.cmp_a !== want.cmp_a || got.cmp_b !== want.cmp_b ||
            got.standby_n !== want.standby_n || got.rev_a !== want.rev_a ||
            got.rev_b !== want.rev_b) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: result %0d mismatch: expected pins %b cmp_a %0d cmp_b %0d stby_n %b rev %b%b",
                     results_checked,
                     {want.b_in2, want.b_in1, want.a_in2, want.a_in1}, want.cmp_a,
                     want.cmp_b, want.standby_n, want.rev_b, want.rev_a);
            $display("tb:   got pins %b cmp_a %0d cmp_b %0d stby_n %b rev %b%b",
                     {got.b_in2, got.b_in1, got.a_in2, got.a_in1}, got.cmp_a,
                     got.cmp_b, got.standby_n, got.rev_b, got.rev_a);
          end
        end
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_directed_commands();
    test_register_extremes();
    test_random_traffic(200, 37, 59, 16'($urandom), 16'($urandom_range(1, 200)),
                        16'($urandom_range(150)));
    test_random_traffic(200, 59, 37, hbsr_pkg::AR_RESET, 16'(hbsr_pkg::STEP_RESET),
                        hbsr_pkg::WAIT_RESET);
    test_random_traffic(200, 0, 0, 16'($urandom), 16'($urandom_range(1, 1023)),
                        16'($urandom));
    wait_all_results();
    $display("tb: %0d items sent, %0d results checked, %0d register writes",
             items_sent, results_checked, reg_writes);
    $display("tb: %0d reversal sequences started, %0d completed", rev_started, rev_finished);
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
